>>> hw/rtl/lpe_pkg.sv
// lpe_pkg: widths, constants and control structs of the legendre polynomial evaluator
// used by lpe_ctrl, lpe_datapath and legendre_polynomial_evaluator
`default_nettype none
package lpe_pkg;
	localparam int MAX_DEGREE = 63;
	localparam int FRAC_BITS  = 30;

	localparam int DEG_W = 6;
	localparam int VAL_W = 32;
	localparam int DER_W = 48;

	// step index and degree width
	localparam int NW = $clog2(MAX_DEGREE + 1);
	localparam int KW = NW + 1;
	// magnitude of a value in [-1,1]
	localparam int ONE_W = FRAC_BITS + 1;
	// |x|*|cur|, then times (2i+1)
	localparam int PXC_W = 2 * FRAC_BITS + 1;
	localparam int T1_W  = 2 * FRAC_BITS + KW;
	localparam int T2_W  = NW + ONE_W;
	localparam int NUM_W = T1_W + 2;
	localparam int MAG_W = NUM_W - 1;
	localparam int Q1_W  = MAG_W - FRAC_BITS;
	// derivative divide
	localparam int A_W   = NW + ONE_W;
	localparam int D_W   = 2 * FRAC_BITS + 2;
	localparam int STEP_DIV_BITS = Q1_W;
	localparam int DER_DIV_BITS  = A_W + 2 * FRAC_BITS;
	localparam int CNT_W = $clog2(DER_DIV_BITS + 1);

	localparam logic [ONE_W-1:0] ONE_MAG = ONE_W'(1) << FRAC_BITS;
	localparam logic signed [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;
	localparam logic [DER_W-1:0] DER_LIMIT = {1'b0, {(DER_W-1){1'b1}}};

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic sub;
		logic div_step;
		logic round;
		logic der_init;
		logic der_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic more_steps;
	} dp_status_t;
endpackage
`default_nettype wire

>>> hw/rtl/lpe_ctrl.sv
// lpe_ctrl: sequencer of the recurrence steps and the two bit-serial divides
// depends on lpe_pkg
`default_nettype none
module lpe_ctrl (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  logic               in_valid,
	output       logic               in_stall,
	output       logic               out_valid,
	input  wire  logic               out_stall,
	input  wire  lpe_pkg::dp_status_t status,
	output       lpe_pkg::ctrl_cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_LOOP, S_MUL1, S_MUL2, S_SUB, S_DIV, S_RND, S_DMUL, S_DDIV, S_FIN
	} state_t;

	state_t state_q;
	logic [lpe_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load     = in_valid;
			S_MUL1: cmd.mul1     = 1'b1;
			S_MUL2: cmd.mul2     = 1'b1;
			S_SUB:  cmd.sub      = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_RND:  cmd.round    = 1'b1;
			S_DMUL: cmd.der_init = 1'b1;
			S_DDIV: cmd.der_step = 1'b1;
			S_FIN:  cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_LOOP;
				end
				S_LOOP: begin
					state_q <= status.more_steps ? S_MUL1 : S_DMUL;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SUB;
				S_SUB: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lpe_pkg::CNT_W'(lpe_pkg::STEP_DIV_BITS - 1))
						state_q <= S_RND;
				end
				S_RND: state_q <= S_LOOP;
				S_DMUL: begin
					cnt_q   <= '0;
					state_q <= S_DDIV;
				end
				S_DDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lpe_pkg::CNT_W'(lpe_pkg::DER_DIV_BITS - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lpe_datapath.sv
// lpe_datapath: recurrence registers, multipliers, restoring dividers and result register
// depends on lpe_pkg, driven by lpe_ctrl commands
`default_nettype none
module lpe_datapath (
	input  wire  logic                              clk,
	input  wire  lpe_pkg::ctrl_cmd_t                cmd,
	output       lpe_pkg::dp_status_t               status,
	input  wire  logic [lpe_pkg::DEG_W-1:0]         degree,
	input  wire  logic signed [lpe_pkg::VAL_W-1:0]  x_value,
	output       logic signed [lpe_pkg::VAL_W-1:0]  poly_value,
	output       logic signed [lpe_pkg::DER_W-1:0]  root_derivative,
	output       logic                              derivative_saturated
);
	localparam int NW    = lpe_pkg::NW;
	localparam int FB    = lpe_pkg::FRAC_BITS;
	localparam int VW    = lpe_pkg::VAL_W;
	localparam int OW    = lpe_pkg::ONE_W;

	logic [NW-1:0] n_q, i_q;
	logic [OW-1:0] ax_q;
	logic xneg_q;
	logic signed [VW-1:0] cur_q, prev_q;
	logic [lpe_pkg::PXC_W-1:0] pxc_q;
	logic [lpe_pkg::T1_W-1:0] t1_q;
	logic [lpe_pkg::T2_W-1:0] t2_q;
	logic t1neg_q, t2neg_q, numneg_q;
	logic [lpe_pkg::Q1_W-1:0] dq_q;
	logic [FB-1:0] rl_q;
	logic [NW-1:0] rem_q;
	logic [lpe_pkg::A_W-1:0] ash_q;
	logic [lpe_pkg::D_W-1:0] d_q, drem_q;
	logic [lpe_pkg::DER_W-1:0] dquo_q;
	logic dsticky_q, dneg_q, azero_q;
	logic signed [VW-1:0] poly_q;
	logic signed [lpe_pkg::DER_W-1:0] der_q;
	logic flag_q;

	// input clamping
	logic [NW-1:0] n_in;
	logic signed [VW-1:0] x_in;
	assign n_in = (degree > lpe_pkg::DEG_W'(lpe_pkg::MAX_DEGREE))
		? NW'(lpe_pkg::MAX_DEGREE) : NW'(degree);
	always_comb begin
		if (x_value > lpe_pkg::ONE_VAL)
			x_in = lpe_pkg::ONE_VAL;
		else if (x_value < -lpe_pkg::ONE_VAL)
			x_in = -lpe_pkg::ONE_VAL;
		else
			x_in = x_value;
	end

	logic [VW-1:0] x_abs, cur_abs, prev_abs;
	assign x_abs    = x_in[VW-1] ? VW'(-x_in) : VW'(x_in);
	assign cur_abs  = cur_q[VW-1] ? VW'(-cur_q) : VW'(cur_q);
	assign prev_abs = prev_q[VW-1] ? VW'(-prev_q) : VW'(prev_q);

	logic [NW-1:0] div_v;
	logic [lpe_pkg::KW-1:0] k_v;
	assign div_v = i_q + 1'b1;
	assign k_v   = {i_q, 1'b1};
	assign status.more_steps = (i_q < n_q);

	// numerator of one step
	logic signed [lpe_pkg::NUM_W-1:0] s1, s2, num;
	logic [lpe_pkg::NUM_W-1:0] num_abs;
	always_comb begin
		s1 = $signed({2'b00, t1_q});
		if (t1neg_q)
			s1 = -s1;
		s2 = $signed(lpe_pkg::NUM_W'({t2_q, {FB{1'b0}}}));
		if (t2neg_q)
			s2 = -s2;
		num = s1 - s2;
		num_abs = num[lpe_pkg::NUM_W-1] ? lpe_pkg::NUM_W'(-num) : lpe_pkg::NUM_W'(num);
	end

	// restoring step for the recurrence divide
	logic [NW:0] r_try;
	logic r_ge;
	assign r_try = {rem_q, dq_q[lpe_pkg::Q1_W-1]};
	assign r_ge  = (r_try >= {1'b0, div_v});

	// rounding, half away from zero
	logic rnd_up;
	logic [lpe_pkg::Q1_W:0] q_rnd;
	logic [VW-1:0] q_mag;
	logic signed [VW-1:0] step_val;
	assign rnd_up = ({rem_q, rl_q, 1'b0} >= {1'b0, div_v, {FB{1'b0}}});
	assign q_rnd  = {1'b0, dq_q} + (lpe_pkg::Q1_W+1)'(rnd_up);
	assign q_mag  = (q_rnd > (lpe_pkg::Q1_W+1)'(lpe_pkg::ONE_MAG))
		? VW'(lpe_pkg::ONE_MAG) : q_rnd[VW-1:0];
	assign step_val = numneg_q ? $signed(-q_mag) : $signed(q_mag);

	// restoring step for the derivative divide
	logic [lpe_pkg::D_W:0] dr_try;
	logic dr_ge;
	logic [lpe_pkg::DER_W-1:0] dq_next;
	assign dr_try  = {drem_q, ash_q[lpe_pkg::A_W-1]};
	assign dr_ge   = (dr_try >= {1'b0, d_q});
	assign dq_next = {dquo_q[lpe_pkg::DER_W-2:0], dr_ge};

	logic [lpe_pkg::DER_W-1:0] der_mag;
	always_comb begin
		if (n_q == '0)
			der_mag = '0;
		else if (d_q == '0)
			der_mag = azero_q ? '0 : lpe_pkg::DER_LIMIT;
		else if (dsticky_q)
			der_mag = lpe_pkg::DER_LIMIT;
		else
			der_mag = dquo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= n_in;
			i_q    <= NW'(1);
			ax_q   <= x_abs[OW-1:0];
			xneg_q <= x_in[VW-1];
			cur_q  <= (n_in == '0) ? lpe_pkg::ONE_VAL : x_in;
			prev_q <= (n_in == '0) ? '0 : lpe_pkg::ONE_VAL;
		end
		if (cmd.mul1)
			pxc_q <= lpe_pkg::PXC_W'(ax_q * cur_abs[OW-1:0]);
		if (cmd.mul2) begin
			t1_q    <= lpe_pkg::T1_W'(pxc_q * k_v);
			t2_q    <= lpe_pkg::T2_W'(i_q * prev_abs[OW-1:0]);
			t1neg_q <= xneg_q ^ cur_q[VW-1];
			t2neg_q <= prev_q[VW-1];
		end
		if (cmd.sub) begin
			dq_q     <= num_abs[lpe_pkg::MAG_W-1:FB];
			rl_q     <= num_abs[FB-1:0];
			numneg_q <= num[lpe_pkg::NUM_W-1];
			rem_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= r_ge ? NW'(r_try - {1'b0, div_v}) : r_try[NW-1:0];
			dq_q  <= {dq_q[lpe_pkg::Q1_W-2:0], r_ge};
		end
		if (cmd.round) begin
			prev_q <= cur_q;
			cur_q  <= step_val;
			i_q    <= i_q + 1'b1;
		end
		if (cmd.der_init) begin
			ash_q     <= lpe_pkg::A_W'(n_q * prev_abs[OW-1:0]);
			azero_q   <= (prev_q == '0);
			dneg_q    <= prev_q[VW-1];
			d_q       <= lpe_pkg::D_W'((lpe_pkg::ONE_MAG - ax_q) *
				({1'b0, lpe_pkg::ONE_MAG} + {1'b0, ax_q}));
			drem_q    <= '0;
			dquo_q    <= '0;
			dsticky_q <= 1'b0;
		end
		if (cmd.der_step) begin
			ash_q     <= {ash_q[lpe_pkg::A_W-2:0], 1'b0};
			drem_q    <= dr_ge ? lpe_pkg::D_W'(dr_try - {1'b0, d_q})
				: dr_try[lpe_pkg::D_W-1:0];
			dquo_q    <= dq_next;
			dsticky_q <= dsticky_q | dq_next[lpe_pkg::DER_W-1];
		end
		if (cmd.out_load) begin
			poly_q <= cur_q;
			der_q  <= dneg_q ? $signed(-der_mag) : $signed(der_mag);
			flag_q <= (n_q != '0) && ((d_q == '0) || dsticky_q);
		end
	end

	assign poly_value           = poly_q;
	assign root_derivative      = der_q;
	assign derivative_saturated = flag_q;
endmodule
`default_nettype wire

>>> hw/rtl/legendre_polynomial_evaluator.sv
// legendre_polynomial_evaluator: top level, controller plus datapath
// depends on lpe_pkg, lpe_ctrl, lpe_datapath
//
// usage: one request on the input channel (degree, x_value in Q1.30) gives
// one request on the output channel: P_n(x) in Q1.30, n*P_{n-1}(x)/(1-x^2)
// in Q17.30 and a saturation flag. both channels use valid/stall; an item
// moves on an edge with valid high and stall low.
// the block works on one request at a time. each recurrence step runs a
// loop check, two multiplies, a subtract, a bit-serial divide by i+1 and
// a rounding step, max(n-1,0) times; the final derivative divide is
// bit-serial as well.
// a result sits in the output register while the next request is taken;
// if the receiver stalls, the next result waits in its final state until
// the output register frees. reset clears the controller and drops valid.
`default_nettype none
module legendre_polynomial_evaluator (
	input  wire  logic                              clk,
	input  wire  logic                              arst_n,
	input  wire  logic                              in_valid,
	output       logic                              in_stall,
	input  wire  logic [lpe_pkg::DEG_W-1:0]         degree,
	input  wire  logic signed [lpe_pkg::VAL_W-1:0]  x_value,
	output       logic                              out_valid,
	input  wire  logic                              out_stall,
	output       logic signed [lpe_pkg::VAL_W-1:0]  poly_value,
	output       logic signed [lpe_pkg::DER_W-1:0]  root_derivative,
	output       logic                              derivative_saturated
);
	lpe_pkg::ctrl_cmd_t  cmd;
	lpe_pkg::dp_status_t status;

	lpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lpe_datapath u_dp (
		.clk                  (clk),
		.cmd                  (cmd),
		.status               (status),
		.degree               (degree),
		.x_value              (x_value),
		.poly_value           (poly_value),
		.root_derivative      (root_derivative),
		.derivative_saturated (derivative_saturated)
	);
endmodule
`default_nettype wire
